>>> hw/rtl/isme_pkg.sv
// Package for the interval set merge engine: opcodes, controller command
// and datapath status types. No dependencies.
`default_nettype none

package isme_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_MEMBER = 2'd1;
    localparam logic [1:0] OP_GAPS   = 2'd2;
    localparam logic [1:0] OP_WGAPS  = 2'd3;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_K,
        RD_ZERO,
        RD_LAST
    } rd_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CLR,
        IDX_ONE,
        IDX_INC,
        IDX_DEC,
        IDX_COUNT,
        IDX_LO1
    } idx_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT,
        WR_MERGE,
        WR_NEW
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_SUB
    } cnt_op_t;

    typedef enum logic [2:0] {
        GAP_NONE,
        GAP_WINDOW,
        GAP_LEAD,
        GAP_INNER,
        GAP_TRAIL
    } gap_src_t;

    typedef struct packed {
        logic     accept;
        rd_sel_t  rd_sel;
        idx_op_t  idx_op;
        logic     scan_upd;
        wr_op_t   wr_op;
        cnt_op_t  cnt_op;
        logic     cap_head;
        logic     cap_tail;
        gap_src_t gap;
        logic     set_status;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       idx_lt_count;
        logic       idx_gt_p;
        logic       cmp_more;
        logic       k_zero;
        logic       full;
        logic       range_empty;
        logic       hull_miss;
        logic       lead_gap;
        logic       trail_gap;
        logic       out_free;
        logic       pend_can;
    } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/interval_set_merge_engine_core.sv
// Top level of the interval set merge engine: joins isme_ctrl and isme_dp.
// Depends on isme_pkg, isme_ctrl and isme_dp.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  cmd     | cmd_valid / cmd_stall | opcode, range_start, range_end,
//          |                       | query_position
//  rsp     | rsp_valid / rsp_stall | member_found, gap_valid, gap_start,
//          |                       | gap_end, last_result, status,
//          |                       | interval_count
//
// One item at a time; the table is a memory with registered read, so each
// entry visited takes a read state and a following state that uses the data.
// Reset clears the interval count and the controller; table words need no
// clearing. A stalled result holds the gap listing at its next result.
`default_nettype none

module interval_set_merge_engine_core #(
    parameter int TABLE_DEPTH    = 16,
    parameter int POSITION_WIDTH = 31
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cmd_valid,
    output logic                              cmd_stall,
    input  wire  [1:0]                        opcode,
    input  wire  [POSITION_WIDTH-1:0]         range_start,
    input  wire  [POSITION_WIDTH-1:0]         range_end,
    input  wire  [POSITION_WIDTH-1:0]         query_position,
    output logic                              rsp_valid,
    input  wire                               rsp_stall,
    output logic                              member_found,
    output logic                              gap_valid,
    output logic [POSITION_WIDTH-1:0]         gap_start,
    output logic [POSITION_WIDTH-1:0]         gap_end,
    output logic                              last_result,
    output logic                              status,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]  interval_count
);

    // command and status bundles between controller and datapath
    isme_pkg::cmd_t cmd;
    isme_pkg::sts_t sts;

    // sequence scans, shifts and result transfers
    isme_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // hold the table, scan state, pending gap and result register
    isme_dp #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (opcode),
        .range_start    (range_start),
        .range_end      (range_end),
        .query_position (query_position),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .member_found   (member_found),
        .gap_valid      (gap_valid),
        .gap_start      (gap_start),
        .gap_end        (gap_end),
        .last_result    (last_result),
        .status         (status),
        .interval_count (interval_count)
    );

endmodule

`default_nettype wire

>>> hw/rtl/isme_dp.sv
// Datapath of the interval set merge engine: interval table memory,
// scan registers, pending gap and result register. Uses isme_pkg.
`default_nettype none

module isme_dp #(
    parameter int TABLE_DEPTH    = 16,
    parameter int POSITION_WIDTH = 31
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire  isme_pkg::cmd_t              cmd,
    output isme_pkg::sts_t                    sts,
    input  wire  [1:0]                        opcode,
    input  wire  [POSITION_WIDTH-1:0]         range_start,
    input  wire  [POSITION_WIDTH-1:0]         range_end,
    input  wire  [POSITION_WIDTH-1:0]         query_position,
    output logic                              rsp_valid,
    input  wire                               rsp_stall,
    output logic                              member_found,
    output logic                              gap_valid,
    output logic [POSITION_WIDTH-1:0]         gap_start,
    output logic [POSITION_WIDTH-1:0]         gap_end,
    output logic                              last_result,
    output logic                              status,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]  interval_count
);

    localparam int PW = POSITION_WIDTH;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [PW-1:0] mem_start [TABLE_DEPTH];
    logic [PW-1:0] mem_end   [TABLE_DEPTH];

    logic [1:0]    op_reg;
    logic [PW-1:0] s_reg, e_reg, q_reg;
    logic [PW-1:0] rd_s_reg, rd_e_reg;
    logic [PW-1:0] ns_reg, ne_reg, hs_reg, he_reg, prev_e_reg;
    logic [PW-1:0] pend_s_reg, pend_e_reg;
    logic          pend_valid_reg;
    logic [CW-1:0] count_reg, idx_reg, k_reg, p_reg;
    logic [AW-1:0] lo_reg;
    logic          found_reg, status_reg;
    logic          out_valid_reg;

    logic [CW-1:0] idx_m1, count_m1;
    logic [CW:0]   idx_k;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [PW-1:0] wr_s, wr_e;
    logic          wr_en;
    logic [PW-1:0] ms, me, new_s, new_e;
    logic          overlap, out_free;

    assign idx_m1   = idx_reg - 1'b1;
    assign count_m1 = count_reg - 1'b1;
    assign idx_k    = {1'b0, idx_reg} + {1'b0, k_reg} - 1'b1;

    always_comb
    begin
        case (cmd.rd_sel)
            isme_pkg::RD_IDX:    rd_addr = idx_reg[AW-1:0];
            isme_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
            isme_pkg::RD_IDX_K:  rd_addr = idx_k[AW-1:0];
            isme_pkg::RD_LAST:   rd_addr = count_m1[AW-1:0];
            default:             rd_addr = '0;
        endcase
    end

    always_comb
    begin
        wr_en = 1'b1;
        case (cmd.wr_op)
            isme_pkg::WR_SHIFT:
            begin
                wr_addr = idx_reg[AW-1:0];
                wr_s    = rd_s_reg;
                wr_e    = rd_e_reg;
            end
            isme_pkg::WR_MERGE:
            begin
                wr_addr = lo_reg;
                wr_s    = ns_reg;
                wr_e    = ne_reg;
            end
            isme_pkg::WR_NEW:
            begin
                wr_addr = p_reg[AW-1:0];
                wr_s    = s_reg;
                wr_e    = e_reg;
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_addr = '0;
                wr_s    = s_reg;
                wr_e    = e_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_start[wr_addr] <= wr_s;
            mem_end[wr_addr]   <= wr_e;
        end
        if (cmd.rd_sel != isme_pkg::RD_NONE)
        begin
            rd_s_reg <= mem_start[rd_addr];
            rd_e_reg <= mem_end[rd_addr];
        end
    end

    // strict overlap of the entry just read with the insert range
    assign ms      = (rd_s_reg > s_reg) ? rd_s_reg : s_reg;
    assign me      = (rd_e_reg < e_reg) ? rd_e_reg : e_reg;
    assign overlap = ms < me;

    always_comb
    begin
        case (cmd.gap)
            isme_pkg::GAP_WINDOW:
            begin
                new_s = s_reg;
                new_e = e_reg;
            end
            isme_pkg::GAP_LEAD:
            begin
                new_s = s_reg;
                new_e = hs_reg;
            end
            isme_pkg::GAP_INNER:
            begin
                new_s = prev_e_reg;
                new_e = rd_s_reg;
            end
            default:
            begin
                new_s = he_reg;
                new_e = e_reg;
            end
        endcase
    end

    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        sts.op           = op_reg;
        sts.idx_lt_count = idx_reg < count_reg;
        sts.idx_gt_p     = idx_reg > p_reg;
        sts.cmp_more     = idx_k < {1'b0, count_reg};
        sts.k_zero       = k_reg == '0;
        sts.full         = count_reg == CW'(TABLE_DEPTH);
        sts.range_empty  = e_reg <= s_reg;
        sts.hull_miss    = (count_reg == '0) ||
                           !(((s_reg > hs_reg) ? s_reg : hs_reg) <
                             ((e_reg < he_reg) ? e_reg : he_reg));
        sts.lead_gap     = s_reg < hs_reg;
        sts.trail_gap    = he_reg < e_reg;
        sts.out_free     = out_free;
        sts.pend_can     = !pend_valid_reg || out_free;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= opcode;
            s_reg  <= range_start;
            e_reg  <= range_end;
            q_reg  <= query_position;
            ns_reg <= range_start;
            ne_reg <= range_end;
        end
        if (cmd.scan_upd && overlap)
        begin
            if (k_reg == '0)
            begin
                lo_reg <= idx_reg[AW-1:0];
            end
            if (rd_s_reg < ns_reg)
            begin
                ns_reg <= rd_s_reg;
            end
            if (rd_e_reg > ne_reg)
            begin
                ne_reg <= rd_e_reg;
            end
        end
        if (cmd.cap_head)
        begin
            hs_reg     <= rd_s_reg;
            prev_e_reg <= rd_e_reg;
        end
        if (cmd.cap_tail)
        begin
            he_reg <= rd_e_reg;
        end
        if (cmd.gap == isme_pkg::GAP_INNER)
        begin
            prev_e_reg <= rd_e_reg;
        end
        if (cmd.gap != isme_pkg::GAP_NONE)
        begin
            pend_s_reg <= new_s;
            pend_e_reg <= new_e;
        end
        if ((cmd.gap != isme_pkg::GAP_NONE) && pend_valid_reg)
        begin
            member_found <= 1'b0;
            gap_valid    <= 1'b1;
            gap_start    <= pend_s_reg;
            gap_end      <= pend_e_reg;
            last_result  <= 1'b0;
            status       <= 1'b0;
        end
        else if (cmd.finish)
        begin
            member_found <= found_reg;
            gap_valid    <= pend_valid_reg;
            gap_start    <= pend_valid_reg ? pend_s_reg : '0;
            gap_end      <= pend_valid_reg ? pend_e_reg : '0;
            last_result  <= 1'b1;
            status       <= status_reg;
        end
        if (((cmd.gap != isme_pkg::GAP_NONE) && pend_valid_reg) || cmd.finish)
        begin
            interval_count <= count_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            k_reg          <= '0;
            p_reg          <= '0;
            found_reg      <= 1'b0;
            status_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            case (cmd.idx_op)
                isme_pkg::IDX_CLR:   idx_reg <= '0;
                isme_pkg::IDX_ONE:   idx_reg <= CW'(1);
                isme_pkg::IDX_INC:   idx_reg <= idx_reg + 1'b1;
                isme_pkg::IDX_DEC:   idx_reg <= idx_m1;
                isme_pkg::IDX_COUNT: idx_reg <= count_reg;
                isme_pkg::IDX_LO1:   idx_reg <= CW'(lo_reg) + 1'b1;
                default:             idx_reg <= idx_reg;
            endcase
            case (cmd.cnt_op)
                isme_pkg::CNT_INC: count_reg <= count_reg + 1'b1;
                isme_pkg::CNT_SUB: count_reg <= count_reg - k_reg + 1'b1;
                default:           count_reg <= count_reg;
            endcase
            if (cmd.accept)
            begin
                k_reg      <= '0;
                p_reg      <= '0;
                found_reg  <= 1'b0;
                status_reg <= 1'b0;
            end
            if (cmd.scan_upd)
            begin
                if (overlap)
                begin
                    k_reg <= k_reg + 1'b1;
                end
                if (rd_s_reg <= s_reg)
                begin
                    p_reg <= p_reg + 1'b1;
                end
                if ((op_reg == isme_pkg::OP_MEMBER) && (rd_s_reg <= q_reg) &&
                    (q_reg < rd_e_reg))
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.set_status)
            begin
                status_reg <= 1'b1;
            end
            if (cmd.gap != isme_pkg::GAP_NONE)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (((cmd.gap != isme_pkg::GAP_NONE) && pend_valid_reg) || cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/isme_ctrl.sv
// Controller of the interval set merge engine: sequences scans, shifts and
// gap listings by commands to isme_dp. Uses isme_pkg.
`default_nettype none

module isme_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_stall,
    input  wire isme_pkg::sts_t sts,
    output isme_pkg::cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_END,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_CMP_RD,
        S_CMP_WR,
        S_GAP_HEAD,
        S_GAP_TAIL,
        S_GAP_LAST,
        S_GAP_DEC,
        S_GAP_RD,
        S_GAP_EM,
        S_GAP_TRAIL,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;
    logic   win;

    assign win = sts.op == isme_pkg::OP_WGAPS;

    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = isme_pkg::RD_NONE;
        cmd.idx_op     = isme_pkg::IDX_HOLD;
        cmd.wr_op      = isme_pkg::WR_NONE;
        cmd.cnt_op     = isme_pkg::CNT_HOLD;
        cmd.gap        = isme_pkg::GAP_NONE;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !stall_reg)
                begin
                    cmd.accept = 1'b1;
                    cmd.idx_op = isme_pkg::IDX_CLR;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.op == isme_pkg::OP_INSERT)
                begin
                    state_next = sts.range_empty ? S_FIN : S_SCAN_RD;
                end
                else if (sts.op == isme_pkg::OP_MEMBER)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_GAP_HEAD;
                end
            end
            S_SCAN_RD:
            begin
                if (sts.idx_lt_count)
                begin
                    cmd.rd_sel = isme_pkg::RD_IDX;
                    state_next = S_SCAN_CHK;
                end
                else
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.scan_upd = 1'b1;
                cmd.idx_op   = isme_pkg::IDX_INC;
                state_next   = S_SCAN_RD;
            end
            S_SCAN_END:
            begin
                if (sts.op == isme_pkg::OP_MEMBER)
                begin
                    state_next = S_FIN;
                end
                else if (!sts.k_zero)
                begin
                    cmd.wr_op  = isme_pkg::WR_MERGE;
                    cmd.idx_op = isme_pkg::IDX_LO1;
                    state_next = S_CMP_RD;
                end
                else if (sts.full)
                begin
                    cmd.set_status = 1'b1;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.idx_op = isme_pkg::IDX_COUNT;
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (sts.idx_gt_p)
                begin
                    cmd.rd_sel = isme_pkg::RD_IDX_M1;
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    cmd.wr_op  = isme_pkg::WR_NEW;
                    cmd.cnt_op = isme_pkg::CNT_INC;
                    state_next = S_FIN;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_op  = isme_pkg::WR_SHIFT;
                cmd.idx_op = isme_pkg::IDX_DEC;
                state_next = S_SHIFT_RD;
            end
            S_CMP_RD:
            begin
                if (sts.cmp_more)
                begin
                    cmd.rd_sel = isme_pkg::RD_IDX_K;
                    state_next = S_CMP_WR;
                end
                else
                begin
                    cmd.cnt_op = isme_pkg::CNT_SUB;
                    state_next = S_FIN;
                end
            end
            S_CMP_WR:
            begin
                cmd.wr_op  = isme_pkg::WR_SHIFT;
                cmd.idx_op = isme_pkg::IDX_INC;
                state_next = S_CMP_RD;
            end
            S_GAP_HEAD:
            begin
                cmd.rd_sel = isme_pkg::RD_ZERO;
                state_next = S_GAP_TAIL;
            end
            S_GAP_TAIL:
            begin
                cmd.cap_head = 1'b1;
                cmd.rd_sel   = isme_pkg::RD_LAST;
                state_next   = S_GAP_LAST;
            end
            S_GAP_LAST:
            begin
                cmd.cap_tail = 1'b1;
                state_next   = S_GAP_DEC;
            end
            S_GAP_DEC:
            begin
                cmd.idx_op = isme_pkg::IDX_ONE;
                if (win && sts.range_empty)
                begin
                    state_next = S_FIN;
                end
                else if (win && sts.hull_miss)
                begin
                    cmd.gap    = isme_pkg::GAP_WINDOW;
                    state_next = S_FIN;
                end
                else
                begin
                    if (win && sts.lead_gap)
                    begin
                        cmd.gap = isme_pkg::GAP_LEAD;
                    end
                    state_next = S_GAP_RD;
                end
            end
            S_GAP_RD:
            begin
                if (sts.idx_lt_count)
                begin
                    cmd.rd_sel = isme_pkg::RD_IDX;
                    state_next = S_GAP_EM;
                end
                else
                begin
                    state_next = S_GAP_TRAIL;
                end
            end
            S_GAP_EM:
            begin
                if (sts.pend_can)
                begin
                    cmd.gap    = isme_pkg::GAP_INNER;
                    cmd.idx_op = isme_pkg::IDX_INC;
                    state_next = S_GAP_RD;
                end
            end
            S_GAP_TRAIL:
            begin
                if (win && sts.trail_gap)
                begin
                    if (sts.pend_can)
                    begin
                        cmd.gap    = isme_pkg::GAP_TRAIL;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= state_next != S_IDLE;
        end
    end

    assign cmd_stall = stall_reg;

endmodule

`default_nettype wire

>>> hw/rtl/isme_checker.sv
// Port-level checker for interval_set_merge_engine_core and its bind.
// Depends on the top level's ports only.
`default_nettype none

module isme_checker #(
    parameter int TABLE_DEPTH    = 16,
    parameter int POSITION_WIDTH = 31
) (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              cmd_valid,
    input wire                              cmd_stall,
    input wire                              rsp_valid,
    input wire                              rsp_stall,
    input wire                              member_found,
    input wire                              gap_valid,
    input wire [POSITION_WIDTH-1:0]         gap_start,
    input wire [POSITION_WIDTH-1:0]         gap_end,
    input wire                              last_result,
    input wire                              status,
    input wire [$clog2(TABLE_DEPTH+1)-1:0]  interval_count
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(gap_start) &&
        $stable(gap_end) && $stable(last_result) && $stable(interval_count))
        else $error("stalled result changed");

    // one item at a time: a transfer in blocks the next cycle
    a_cmd_block: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command accepted back to back");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> interval_count <= TABLE_DEPTH)
        else $error("interval count above table depth");

    // full status and membership hits stand alone in a single-result item
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status || member_found) |-> last_result && !gap_valid)
        else $error("status or hit on a gap result");

endmodule

bind interval_set_merge_engine_core isme_checker #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .POSITION_WIDTH (POSITION_WIDTH)
) u_isme_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .member_found   (member_found),
    .gap_valid      (gap_valid),
    .gap_start      (gap_start),
    .gap_end        (gap_end),
    .last_result    (last_result),
    .status         (status),
    .interval_count (interval_count)
);

`default_nettype wire

>>> tb/interval_set_merge_engine_core_tb.sv
// Self-checking testbench for the interval set merge engine core: drives
// insert, membership and gap listing commands and checks every response.
// Depends on isme_pkg and interval_set_merge_engine_core.
`timescale 1ns / 1ps

module interval_set_merge_engine_core_tb;

    localparam int DEPTH = 16;
    localparam int PW    = 31;
    localparam logic [PW-1:0] PMAX = '1;

    // One expected response transfer.
    typedef struct packed {
        logic          found;
        logic          gvalid;
        logic [PW-1:0] gstart;
        logic [PW-1:0] gend;
        logic          last;
        logic          stat;
        logic [4:0]    count;
    } rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic [1:0] opcode = isme_pkg::OP_INSERT;
    logic [PW-1:0] range_start = '0;
    logic [PW-1:0] range_end = '0;
    logic [PW-1:0] query_position = '0;
    logic rsp_stall = 1'b0;
    wire cmd_stall;
    wire rsp_valid;
    wire member_found, gap_valid, last_result, status;
    wire [PW-1:0] gap_start, gap_end;
    wire [4:0] interval_count;

    // Shadow copy of the interval table.
    logic [PW-1:0] tbl_start [DEPTH];
    logic [PW-1:0] tbl_end [DEPTH];
    int tbl_count = 0;

    rsp_t pending_rsp [$];
    int errors = 0;
    int idle_pct = 30;
    int hold_off = 0;

    always #2 clk = ~clk;

    interval_set_merge_engine_core #(.TABLE_DEPTH(DEPTH), .POSITION_WIDTH(PW)) u_top (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .opcode(opcode), .range_start(range_start), .range_end(range_end),
        .query_position(query_position),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .member_found(member_found), .gap_valid(gap_valid),
        .gap_start(gap_start), .gap_end(gap_end), .last_result(last_result),
        .status(status), .interval_count(interval_count)
    );

    function automatic rsp_t make_rsp(logic f, logic v, logic [PW-1:0] s, logic [PW-1:0] e,
                                      logic st);
        rsp_t r;
        r.found = f;
        r.gvalid = v;
        r.gstart = v ? s : '0;
        r.gend = v ? e : '0;
        r.last = 1'b0;
        r.stat = st;
        r.count = tbl_count[4:0];
        return r;
    endfunction

    // Apply an insert to the shadow table; return the full status.
    function automatic logic table_insert(logic [PW-1:0] s, logic [PW-1:0] e);
        int lo, hits, p;
        logic [PW-1:0] ns, ne, ms, me;
        lo = 0;
        hits = 0;
        ns = s;
        ne = e;
        if (e <= s) return 1'b0;
        for (int j = 0; j < tbl_count; j++)
        begin
            ms = tbl_start[j] > s ? tbl_start[j] : s;
            me = tbl_end[j] < e ? tbl_end[j] : e;
            if (ms < me)
            begin
                if (hits == 0) lo = j;
                hits++;
                if (tbl_start[j] < ns) ns = tbl_start[j];
                if (tbl_end[j] > ne) ne = tbl_end[j];
            end
        end
        if (hits == 0)
        begin
            if (tbl_count >= DEPTH) return 1'b1;
            p = 0;
            while (p < tbl_count && tbl_start[p] <= s) p++;
            for (int j = tbl_count; j > p; j--)
            begin
                tbl_start[j] = tbl_start[j-1];
                tbl_end[j] = tbl_end[j-1];
            end
            tbl_start[p] = s;
            tbl_end[p] = e;
            tbl_count++;
            return 1'b0;
        end
        tbl_start[lo] = ns;
        tbl_end[lo] = ne;
        for (int j = lo + 1; j + hits - 1 < tbl_count; j++)
        begin
            tbl_start[j] = tbl_start[j+hits-1];
            tbl_end[j] = tbl_end[j+hits-1];
        end
        tbl_count -= hits - 1;
        return 1'b0;
    endfunction

    // Work out the responses of one command and queue them.
    task automatic predict_rsp(logic [1:0] op, logic [PW-1:0] s, logic [PW-1:0] e,
                               logic [PW-1:0] q);
        rsp_t res [$];
        logic f, st, win;
        logic [PW-1:0] ms, me;
        res = {};
        if (op == isme_pkg::OP_INSERT)
        begin
            st = table_insert(s, e);
            res.push_back(make_rsp(1'b0, 1'b0, '0, '0, st));
        end
        else if (op == isme_pkg::OP_MEMBER)
        begin
            f = 1'b0;
            for (int j = 0; j < tbl_count; j++)
                if (tbl_start[j] <= q && q < tbl_end[j]) f = 1'b1;
            res.push_back(make_rsp(f, 1'b0, '0, '0, 1'b0));
        end
        else
        begin
            win = (op == isme_pkg::OP_WGAPS);
            if (tbl_count > 0)
            begin
                ms = s > tbl_start[0] ? s : tbl_start[0];
                me = e < tbl_end[tbl_count-1] ? e : tbl_end[tbl_count-1];
            end
            if (win && e <= s)
                res.push_back(make_rsp(1'b0, 1'b0, '0, '0, 1'b0));
            else if (win && (tbl_count == 0 || !(ms < me)))
                res.push_back(make_rsp(1'b0, 1'b1, s, e, 1'b0));
            else
            begin
                if (win && s < tbl_start[0])
                    res.push_back(make_rsp(1'b0, 1'b1, s, tbl_start[0], 1'b0));
                for (int j = 0; j + 1 < tbl_count; j++)
                    res.push_back(make_rsp(1'b0, 1'b1, tbl_end[j], tbl_start[j+1], 1'b0));
                if (win && tbl_end[tbl_count-1] < e)
                    res.push_back(make_rsp(1'b0, 1'b1, tbl_end[tbl_count-1], e, 1'b0));
                if (res.size() == 0)
                    res.push_back(make_rsp(1'b0, 1'b0, '0, '0, 1'b0));
            end
        end
        res[res.size()-1].last = 1'b1;
        foreach (res[i]) pending_rsp.push_back(res[i]);
    endtask

    // Offer one command until it is taken; predict at acceptance.
    // Drop valid only while idling, so back to back items keep it high.
    task automatic send_cmd(logic [1:0] op, logic [PW-1:0] s, logic [PW-1:0] e,
                            logic [PW-1:0] q);
        if ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        opcode <= op;
        range_start <= s;
        range_end <= e;
        query_position <= q;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        predict_rsp(op, s, e, q);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [PW-1:0] rand_pos();
        case ($urandom_range(3))
            0: return PMAX - PW'($urandom_range(8));
            1: return PW'($urandom);
            default: return PW'($urandom_range(400));
        endcase
    endfunction

    // Receiver: random stall, with a long hold-off when asked.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < idle_pct);
    end

    // Check every response transfer against the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t exp_r, got;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            got = '{member_found, gap_valid, gap_start, gap_end, last_result, status,
                    interval_count};
            if (pending_rsp.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected response %p", got);
            end
            else
            begin
                exp_r = pending_rsp.pop_front();
                if (got !== exp_r)
                begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p got %p", exp_r, got);
                end
            end
        end
    end

    // Extremes, every opcode, touching and empty intervals, window cases.
    task automatic test_directed();
        send_cmd(isme_pkg::OP_GAPS, '0, '0, '0);
        send_cmd(isme_pkg::OP_WGAPS, 10, 20, '0);
        send_cmd(isme_pkg::OP_WGAPS, 20, 10, '0);
        send_cmd(isme_pkg::OP_MEMBER, '0, '0, PMAX);
        send_cmd(isme_pkg::OP_INSERT, 30, 30, '0);
        send_cmd(isme_pkg::OP_INSERT, 10, 20, '0);
        send_cmd(isme_pkg::OP_INSERT, 20, 30, '0);
        send_cmd(isme_pkg::OP_INSERT, 0, 5, '0);
        send_cmd(isme_pkg::OP_INSERT, PMAX - 1, PMAX, '0);
        send_cmd(isme_pkg::OP_MEMBER, '0, '0, 20);
        send_cmd(isme_pkg::OP_MEMBER, '0, '0, 30);
        send_cmd(isme_pkg::OP_MEMBER, '0, '0, PMAX - 1);
        send_cmd(isme_pkg::OP_GAPS, '0, '0, '0);
        send_cmd(isme_pkg::OP_WGAPS, 0, PMAX, '0);
        send_cmd(isme_pkg::OP_WGAPS, 2, 15, '0);
        send_cmd(isme_pkg::OP_INSERT, 4, 26, '0);
        send_cmd(isme_pkg::OP_WGAPS, PMAX, PMAX, '0);
        send_cmd(isme_pkg::OP_INSERT, 0, PMAX, '0);
        send_cmd(isme_pkg::OP_GAPS, '0, '0, '0);
        send_cmd(isme_pkg::OP_MEMBER, '0, '0, '0);
        wait_drained();
    endtask

    // Fill the table to depth, overflow it, list gaps under a long hold-off.
    task automatic test_full_table();
        for (int i = 0; i < DEPTH + 3; i++)
            send_cmd(isme_pkg::OP_INSERT, PW'(i * 1000 + 5000000),
                     PW'(i * 1000 + 5000010), '0);
        hold_off = 300;
        for (int i = 0; i < 6; i++) send_cmd(isme_pkg::OP_WGAPS, 0, PMAX, '0);
        send_cmd(isme_pkg::OP_INSERT, 5000005, 5010000, '0);
        send_cmd(isme_pkg::OP_GAPS, '0, '0, '0);
        wait_drained();
    endtask

    // Random mix of inserts and queries over a clustered position range.
    task automatic test_random(int n, int pct);
        logic [1:0] op;
        logic [PW-1:0] a, b;
        idle_pct = pct;
        for (int i = 0; i < n; i++)
        begin
            op = 2'($urandom_range(3));
            a = rand_pos();
            b = ($urandom_range(9) == 0) ? rand_pos() : a + PW'($urandom_range(60));
            if (b < a && $urandom_range(3) != 0) b = PMAX;
            send_cmd(op, a, b, rand_pos());
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_random(130, 30);
        test_random(50, 0);
        test_random(80, 30);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
